[hw/rtl/shuffled_lehmer_random_generator_macros.svh]
// ----------------------------------------------------------------------------
// shuffled lehmer random generator assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SLRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slrg assertion failed");
// next-cycle implication
`define SLRG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slrg assertion failed");
`else
`define SLRG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLRG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/slrg_pkg.sv]
// ----------------------------------------------------------------------------
// slrg_pkg
// shared constants, controller states and command/status types
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 32;
    localparam int unsigned WARM_EXTRA        = 8;
    localparam int unsigned VAL_W             = 31;
    localparam int unsigned MULT_W            = 15;
    localparam logic [MULT_W-1:0] LEH_MULT    = 15'd16807;
    localparam logic [VAL_W-1:0]  LEH_MOD     = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_FOLD,
        ST_MUL,
        ST_FOLD,
        ST_READ,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic load_seed;  // load generator from seed
        logic mul;        // capture product and slot estimate
        logic fold;       // fold product into generator state
        logic slot_ld;    // capture corrected slot
        logic tbl_we;     // init write of table entry at counter
        logic set_held;   // last warm-up step also sets held value
        logic rd;         // table read at slot
        logic wr;         // commit draw
    } t_cmd;

    typedef struct packed {
        logic held_zero;  // generator not yet seeded
    } t_sts;

endpackage

[hw/rtl/slrg_ctrl.sv]
// ----------------------------------------------------------------------------
// slrg_ctrl
// sequencer for warm-up and draw steps, output valid tracking
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_macros.svh"

module slrg_ctrl #(
    parameter int unsigned TABLE_ENTRIES = slrg_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned CNT_W = $clog2(TABLE_ENTRIES + slrg_pkg::WARM_EXTRA)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  slrg_pkg::t_sts    i_sts,
    output slrg_pkg::t_cmd    o_cmd,
    output logic [CNT_W-1:0]  o_cnt
);

    localparam logic [CNT_W-1:0] CNT_INIT =
        CNT_W'(TABLE_ENTRIES + slrg_pkg::WARM_EXTRA - 1);
    localparam logic [CNT_W-1:0] CNT_TBL = CNT_W'(TABLE_ENTRIES);

    slrg_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;
    logic             w_init;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_init     = i_func || i_sts.held_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slrg_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            slrg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_init ? slrg_pkg::ST_INIT_MUL : slrg_pkg::ST_MUL;
                    n_cnt   = CNT_INIT;
                end
            end
            slrg_pkg::ST_INIT_MUL: n_state = slrg_pkg::ST_INIT_FOLD;
            slrg_pkg::ST_INIT_FOLD: begin
                if (r_cnt == '0) begin
                    n_state = slrg_pkg::ST_MUL;
                end else begin
                    n_state = slrg_pkg::ST_INIT_MUL;
                    n_cnt   = r_cnt - CNT_W'(1);
                end
            end
            slrg_pkg::ST_MUL:  n_state = slrg_pkg::ST_FOLD;
            slrg_pkg::ST_FOLD: n_state = slrg_pkg::ST_READ;
            slrg_pkg::ST_READ: begin
                if (w_out_free) begin
                    n_state = slrg_pkg::ST_WRITE;
                end
            end
            slrg_pkg::ST_WRITE: n_state = slrg_pkg::ST_IDLE;
            default: n_state = slrg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            slrg_pkg::ST_IDLE: begin
                o_cmd.accept    = i_in_valid;
                o_cmd.load_seed = i_in_valid && w_init;
            end
            slrg_pkg::ST_INIT_MUL: o_cmd.mul = 1'b1;
            slrg_pkg::ST_INIT_FOLD: begin
                o_cmd.fold     = 1'b1;
                o_cmd.tbl_we   = r_cnt < CNT_TBL;
                o_cmd.set_held = r_cnt == '0;
            end
            slrg_pkg::ST_MUL: o_cmd.mul = 1'b1;
            slrg_pkg::ST_FOLD: begin
                o_cmd.fold    = 1'b1;
                o_cmd.slot_ld = 1'b1;
            end
            slrg_pkg::ST_READ: o_cmd.rd = 1'b1;
            slrg_pkg::ST_WRITE: begin
                o_cmd.wr    = 1'b1;
                n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_ready  = r_state == slrg_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cnt       = r_cnt;

    // a waiting result is never overwritten
    `SLRG_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_state == slrg_pkg::ST_WRITE, w_out_free)
    // last warm-up step always hands over to the draw
    `SLRG_ASSERT_NXT(a_init_to_draw, i_clk, i_rst_n,
        (r_state == slrg_pkg::ST_INIT_FOLD) && (r_cnt == '0), r_state == slrg_pkg::ST_MUL)
    // an input transfer always starts a step
    `SLRG_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready,
        (r_state == slrg_pkg::ST_INIT_MUL) || (r_state == slrg_pkg::ST_MUL))

endmodule

[hw/rtl/slrg_dp.sv]
// ----------------------------------------------------------------------------
// slrg_dp
// lehmer step, shuffle slot select, shuffle table and result register
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_macros.svh"

module slrg_dp #(
    parameter int unsigned TABLE_ENTRIES = slrg_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned CNT_W = $clog2(TABLE_ENTRIES + slrg_pkg::WARM_EXTRA)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slrg_pkg::t_cmd              i_cmd,
    input  logic [CNT_W-1:0]            i_cnt,
    input  logic [slrg_pkg::VAL_W-1:0]  i_seed,
    output slrg_pkg::t_sts              o_sts,
    output logic [slrg_pkg::VAL_W-1:0]  o_value,
    output logic                        o_did_init
);

    localparam int unsigned VW     = slrg_pkg::VAL_W;
    localparam int unsigned PROD_W = VW + slrg_pkg::MULT_W;
    localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int unsigned Q_W    = $clog2(TABLE_ENTRIES + 2);
    localparam logic [63:0] SLOT_DIV_L =
        64'd1 + (64'(slrg_pkg::LEH_MOD) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam logic [63:0] RECIP_L = (64'd1 << VW) / SLOT_DIV_L;
    localparam int unsigned RECIP_W = $clog2(RECIP_L + 64'd1);
    localparam int unsigned QP_W    = VW + RECIP_W;
    localparam int unsigned QD_W    = VW + Q_W;
    localparam logic [VW-1:0]  SLOT_DIV = VW'(SLOT_DIV_L);
    localparam logic [Q_W-1:0] Q_LAST   = Q_W'(TABLE_ENTRIES - 1);

    logic [VW-1:0]     r_lehmer, r_held;
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    r_qest;
    logic [IDX_W-1:0]  r_slot;
    logic [VW-1:0]     r_rdata;
    logic              r_did;
    logic [VW-1:0]     r_value;
    logic              r_did_out;
    logic [VW-1:0]     r_mem [TABLE_ENTRIES];

    logic [VW-1:0]     w_seed_s;
    logic [VW:0]       w_sum;
    logic [VW-1:0]     w_step;
    logic [QP_W-1:0]   w_qprod;
    logic [QD_W-1:0]   w_qd;
    logic [VW-1:0]     w_rem;
    logic [Q_W-1:0]    w_q1;
    logic [IDX_W-1:0]  w_slot;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [VW-1:0]     w_wdata;

    // zero and the modulus both collapse to one
    assign w_seed_s = ((i_seed == '0) || (i_seed == slrg_pkg::LEH_MOD)) ? VW'(1) : i_seed;

    // mersenne fold: hi + lo, one conditional subtract
    assign w_sum  = (VW+1)'(r_prod[PROD_W-1:VW]) + (VW+1)'(r_prod[VW-1:0]);
    assign w_step = (w_sum >= (VW+1)'(slrg_pkg::LEH_MOD))
                  ? VW'(w_sum - (VW+1)'(slrg_pkg::LEH_MOD)) : w_sum[VW-1:0];

    // reciprocal estimate is low by at most one
    assign w_qprod = QP_W'(r_held) * QP_W'(RECIP_L);
    assign w_qd    = QD_W'(r_qest) * QD_W'(SLOT_DIV);
    assign w_rem   = r_held - w_qd[VW-1:0];
    assign w_q1    = (w_rem >= SLOT_DIV) ? r_qest + Q_W'(1) : r_qest;
    assign w_slot  = (w_q1 > Q_LAST) ? IDX_W'(Q_LAST) : IDX_W'(w_q1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lehmer <= VW'(1);
            r_held   <= '0;
        end else begin
            if (i_cmd.load_seed) begin
                r_lehmer <= w_seed_s;
            end else if (i_cmd.fold) begin
                r_lehmer <= w_step;
            end
            if (i_cmd.set_held) begin
                r_held <= w_step;
            end else if (i_cmd.wr) begin
                r_held <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_did <= i_cmd.load_seed;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(slrg_pkg::LEH_MULT) * PROD_W'(r_lehmer);
            r_qest <= Q_W'(w_qprod >> VW);
        end
        if (i_cmd.slot_ld) begin
            r_slot <= w_slot;
        end
        if (i_cmd.wr) begin
            r_value   <= r_rdata;
            r_did_out <= r_did;
        end
    end

    // shuffle table, one write port and one registered read port
    assign w_we    = i_cmd.tbl_we || i_cmd.wr;
    assign w_waddr = i_cmd.tbl_we ? i_cnt[IDX_W-1:0] : r_slot;
    assign w_wdata = i_cmd.tbl_we ? w_step : r_lehmer;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_slot];
        end
    end

    assign o_sts.held_zero = r_held == '0;
    assign o_value         = r_value;
    assign o_did_init      = r_did_out;

    // generator never reaches the zero fixed point
    `SLRG_ASSERT_IMP(a_lehmer_nonzero, i_clk, i_rst_n, 1'b1, r_lehmer != '0)
    // every committed draw leaves the block seeded
    `SLRG_ASSERT_NXT(a_held_nonzero, i_clk, i_rst_n, i_cmd.wr, r_held != '0)

endmodule

[hw/rtl/shuffled_lehmer_random_generator.sv]
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// minimal standard lehmer generator with a bays-durham shuffle table
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready   | i_func, i_seed
//  out     | output    | o_out_valid / i_out_ready | o_value, o_did_init
//
// a draw runs these steps per item: the idle state that takes the transfer, a
// lehmer step as a multiply state and a mersenne fold state, a table read and
// a commit; ready comes back when the sequencer returns to idle after the commit
// a reseed (or a draw while unseeded) adds 40 warm-up steps of multiply and fold
// reset gives state one and an unseeded block; the table needs no clearing
// a stalled result holds the commit step back; the result register frees the
// input side, so the next transfer is taken while a result waits
//
module shuffled_lehmer_random_generator #(
    parameter int unsigned TABLE_ENTRIES = slrg_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [slrg_pkg::VAL_W-1:0]  i_seed,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [slrg_pkg::VAL_W-1:0]  o_value,
    output logic                        o_did_init
);

    // warm-up counter spans all warm-up steps
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + slrg_pkg::WARM_EXTRA);

    slrg_pkg::t_cmd   w_cmd;
    slrg_pkg::t_sts   w_sts;
    logic [CNT_W-1:0] w_cnt;

    // sequencer: warm-up countdown, draw steps, output valid
    slrg_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_cnt       (w_cnt)
    );

    // datapath: generator state, held value, shuffle table, result register
    slrg_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CNT_W         (CNT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cnt      (w_cnt),
        .i_seed     (i_seed),
        .o_sts      (w_sts),
        .o_value    (o_value),
        .o_did_init (o_did_init)
    );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the shuffled lehmer generator: every result is compared with a
// model of the minstd step, the warm-up fill and the shuffle table, under
// random idle cycles, a long output stall and drained pauses
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL_N        = slrg_pkg::DEF_TABLE_ENTRIES;
    // divisor that maps a held value onto a table slot
    localparam int unsigned SLOT_DIV     = 32'h7FFF_FFFE / TBL_N + 1;
    localparam int unsigned IDLE_PCT     = 23;
    localparam int unsigned HOLD_CYCLES  = 300;
    // covers the tail of any item, a reseed included
    localparam int unsigned TAIL_CYCLES  = 120;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam logic [slrg_pkg::VAL_W-1:0] SEED_ONES = '1;

    typedef struct packed {
        logic [slrg_pkg::VAL_W-1:0] value;
        logic                       did_init;
    } t_draw;

    // clock, reset and block ports
    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_func   = 1'b0;
    logic [slrg_pkg::VAL_W-1:0] in_seed   = '0;
    logic                       out_ready = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [slrg_pkg::VAL_W-1:0] o_value;
    logic                       o_did_init;

    // shared run control
    bit               no_idle  = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      fail_cnt = 0;
    int unsigned      cyc_cnt  = 0;

    // generator model state
    logic [slrg_pkg::VAL_W-1:0] gen_state = 31'd1;
    logic [slrg_pkg::VAL_W-1:0] gen_held  = '0;
    logic [slrg_pkg::VAL_W-1:0] shuf_tbl [TBL_N];

    // results still owed by the block, oldest first
    t_draw pending_numbers [$];

    shuffled_lehmer_random_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (in_func),
        .i_seed      (in_seed),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_value     (o_value),
        .o_did_init  (o_did_init)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // one minstd step, exact modular product
    function automatic logic [slrg_pkg::VAL_W-1:0] minstd_step(
        input logic [slrg_pkg::VAL_W-1:0] x
    );
        longint unsigned prod;
        prod = 64'(x) * 64'(slrg_pkg::LEH_MULT);
        return slrg_pkg::VAL_W'(prod % 64'(slrg_pkg::LEH_MOD));
    endfunction

    // advance the model by one transfer and queue the number it must give
    function automatic void predict_draw(input logic func,
                                         input logic [slrg_pkg::VAL_W-1:0] seed);
        t_draw                      nxt;
        logic [slrg_pkg::VAL_W-1:0] s;
        int unsigned                slot;
        int                         j;
        nxt.did_init = func || (gen_held == '0);
        if (nxt.did_init) begin
            // all ones equals the modulus and reduces to zero, zero becomes one
            s = (seed == slrg_pkg::LEH_MOD) ? '0 : seed;
            if (s == '0) begin
                s = 31'd1;
            end
            gen_state = s;
            // warm-up: the last table-size steps land in the table, top slot first
            for (j = int'(TBL_N + slrg_pkg::WARM_EXTRA) - 1; j >= 0; j--) begin
                gen_state = minstd_step(gen_state);
                if (j < int'(TBL_N)) begin
                    shuf_tbl[j] = gen_state;
                end
            end
            gen_held = shuf_tbl[0];
        end
        gen_state = minstd_step(gen_state);
        slot = int'(gen_held) / SLOT_DIV;
        if (slot >= TBL_N) begin
            slot = TBL_N - 1;
        end
        gen_held       = shuf_tbl[slot];
        shuf_tbl[slot] = gen_state;
        nxt.value      = gen_held;
        pending_numbers.push_back(nxt);
    endfunction

    // offer one item, idling first at random; valid stays up after the transfer
    task automatic offer_draw(input logic func, input logic [slrg_pkg::VAL_W-1:0] seed);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_seed  <= seed;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_draw(func, seed);
    endtask

    // hold the sender until every owed result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_numbers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // seeds lean on the corners now and then
    function automatic logic [slrg_pkg::VAL_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SEED_ONES;
            2:       return slrg_pkg::VAL_W'($urandom_range(1, 200000));
            3:       return SEED_ONES - slrg_pkg::VAL_W'($urandom_range(0, 3));
            default: return slrg_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // directed corners: unseeded draw, zero seed, modulus seed, extremes
    task automatic test_corner_seeds();
        // draw while unseeded loads from the seed field
        offer_draw(1'b0, '0);
        offer_draw(1'b0, SEED_ONES);
        offer_draw(1'b0, 31'd5);
        // reseed with all ones must act as seed one
        offer_draw(1'b1, SEED_ONES);
        offer_draw(1'b0, '0);
        offer_draw(1'b1, 31'd1);
        offer_draw(1'b0, SEED_ONES);
        offer_draw(1'b1, SEED_ONES - 31'd1);
        offer_draw(1'b0, '0);
        offer_draw(1'b1, 31'd127773);
        offer_draw(1'b1, 31'd16807);
        offer_draw(1'b1, 31'h5555_5555);
        offer_draw(1'b0, 31'h2AAA_AAAA);
        offer_draw(1'b1, 31'h2AAA_AAAA);
        offer_draw(1'b0, 31'h5555_5555);
        offer_draw(1'b1, 31'd2836);
        offer_draw(1'b1, 31'd0);
        offer_draw(1'b0, '0);
        offer_draw(1'b0, '0);
        wait_drained();
    endtask

    // mostly draws with an occasional reseed, random seed field throughout
    task automatic test_random_mix(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            offer_draw(($urandom_range(0, 99) < 10), pick_seed());
        end
        wait_drained();
    endtask

    // long stretch where neither side idles
    task automatic test_back_to_back(input int unsigned n);
        int unsigned i;
        no_idle = 1'b1;
        for (i = 0; i < n; i++) begin
            offer_draw(($urandom_range(0, 99) < 5), pick_seed());
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // receiver stalls for a long time while items keep coming
    task automatic test_output_holdoff(input int unsigned n);
        int unsigned i;
        hold_req = 1'b1;
        for (i = 0; i < n; i++) begin
            offer_draw(($urandom_range(0, 99) < 15), pick_seed());
        end
        wait_drained();
    endtask

    // short bursts, each drained before the next
    task automatic test_sender_pause(input int unsigned bursts);
        int unsigned b;
        int unsigned i;
        for (b = 0; b < bursts; b++) begin
            for (i = 0; i < 5; i++) begin
                offer_draw((i == 0) && b[0], pick_seed());
            end
            wait_drained();
        end
    endtask

    // receiver ready: random idles, or a counted stall when asked
    initial begin : out_ready_drv
        int unsigned k;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end else begin
                out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // result check against the oldest owed number
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_numbers.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result value=%0d did_init=%0b",
                         $time, o_value, o_did_init);
            end else begin
                want = pending_numbers.pop_front();
                if (o_value !== want.value) begin
                    fail_cnt++;
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, o_value);
                end
                if (o_did_init !== want.did_init) begin
                    fail_cnt++;
                    $display("%0t: did_init expected %0b actual %0b",
                             $time, want.did_init, o_did_init);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_seeds();
        test_random_mix(1550);
        test_back_to_back(150);
        test_output_holdoff(30);
        test_sender_pause(6);

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/slrg_pkg.sv
hw/rtl/slrg_ctrl.sv
hw/rtl/slrg_dp.sv
hw/rtl/shuffled_lehmer_random_generator.sv
verif/tb.sv
